// ----- hdl/mexp_pkg.sv -----
package mexp_pkg;

  // Datapath width; every operand, the modulus and the result use it
  localparam int OPERAND_WIDTH = 32;

  // Width of the counter that walks the bits of one operand
  localparam int CNT_W = $clog2(OPERAND_WIDTH);

  // Modulus after reset
  localparam logic [OPERAND_WIDTH-1:0] MOD_RESET = OPERAND_WIDTH'(23);

  // Request to the modular multiplier: x * y mod m, x below m
  typedef struct packed {
    logic                     go;
    logic [OPERAND_WIDTH-1:0] x;
    logic [OPERAND_WIDTH-1:0] y;
  } mm_req_t;

  // Response from the modular multiplier
  typedef struct packed {
    logic                     done;
    logic [OPERAND_WIDTH-1:0] prod;
  } mm_rsp_t;

endpackage

// ----- hdl/modular_exponentiation_top.sv -----
// Modular exponentiation, base ^ exponent mod modulus, by square-and-multiply.
// Pulse start while busy is low to take an item; busy stays high until the
// result has been shown. The result appears on out_power_result for exactly one
// cycle with out_strobe high and must be captured then: there is no way to
// hold it. One bit-serial modular multiplier does all the work, one multiplier
// bit per cycle. An item costs one product to reduce the base, one squaring
// per exponent bit and one extra product per set exponent bit. A modulus
// below 2 gives 0. The modulus register (reset 23) is written through
// cfg_we/cfg_wdata and should only change while busy is low.
module modular_exponentiation_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [mexp_pkg::OPERAND_WIDTH-1:0] in_base_value,
  input  logic [mexp_pkg::OPERAND_WIDTH-1:0] in_exponent_value,
  input  logic                               cfg_we,
  input  logic [mexp_pkg::OPERAND_WIDTH-1:0] cfg_wdata,
  output logic                               out_strobe,
  output logic [mexp_pkg::OPERAND_WIDTH-1:0] out_power_result
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RED  = 3'd1;
  localparam logic [2:0] ST_SQR  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [W-1:0]               modulus_r;
  logic [W-1:0]               base_r, base_nxt;
  logic [W-1:0]               exp_r, exp_nxt;
  logic [W-1:0]               acc_r, acc_nxt;
  logic [mexp_pkg::CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;

  mexp_pkg::mm_req_t mm_req;
  mexp_pkg::mm_rsp_t mm_rsp;

  // Modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mexp_pkg::MOD_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  // Sequence: reduce base, then square (and multiply) per exponent bit
  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    exp_nxt     = exp_r;
    acc_nxt     = acc_r;
    bit_cnt_nxt = bit_cnt_r;
    mm_req.go   = 1'b0;
    mm_req.x    = mm_rsp.prod;
    mm_req.y    = mm_rsp.prod;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          exp_nxt = in_exponent_value;
          if (modulus_r < W'(2)) begin
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            // base mod m computed as 1 * base mod m
            mm_req.go = 1'b1;
            mm_req.x  = W'(1);
            mm_req.y  = in_base_value;
            state_nxt = ST_RED;
          end
        end
      end
      ST_RED: begin
        if (mm_rsp.done) begin
          base_nxt    = mm_rsp.prod;
          bit_cnt_nxt = mexp_pkg::CNT_W'(W - 1);
          mm_req.go   = 1'b1;
          mm_req.x    = W'(1);
          mm_req.y    = W'(1);
          state_nxt   = ST_SQR;
        end
      end
      ST_SQR: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.prod;
          if (exp_r[W-1]) begin
            mm_req.go = 1'b1;
            mm_req.y  = base_r;
            state_nxt = ST_MUL;
          end else begin
            exp_nxt = {exp_r[W-2:0], 1'b0};
            if (bit_cnt_r == '0) begin
              state_nxt = ST_DONE;
            end else begin
              bit_cnt_nxt = bit_cnt_r - 1'b1;
              mm_req.go   = 1'b1;
            end
          end
        end
      end
      ST_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.prod;
          exp_nxt = {exp_r[W-2:0], 1'b0};
          if (bit_cnt_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            bit_cnt_nxt = bit_cnt_r - 1'b1;
            mm_req.go   = 1'b1;
            state_nxt   = ST_SQR;
          end
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      bit_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      bit_cnt_r <= bit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    acc_r  <= acc_nxt;
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mm_req),
    .modulus (modulus_r),
    .rsp     (mm_rsp)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = (state_r == ST_DONE);
  assign out_power_result = acc_r;

endmodule

// ----- hdl/mexp_mulmod.sv -----
module mexp_mulmod (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mexp_pkg::mm_req_t                  req,
  input  logic [mexp_pkg::OPERAND_WIDTH-1:0] modulus,
  output mexp_pkg::mm_rsp_t                  rsp
);

  localparam int W = mexp_pkg::OPERAND_WIDTH;

  logic [W-1:0]                 acc_r, acc_nxt;
  logic [W-1:0]                 x_r;
  logic [W-1:0]                 y_r;
  logic [mexp_pkg::CNT_W-1:0]   cnt_r;
  logic                         run_r;
  logic                         done_r;

  logic [W:0]   dbl;
  logic [W-1:0] dbl_red;
  logic [W:0]   sum;
  logic [W-1:0] sum_red;

  // Double the accumulator, then add x when the current multiplier bit is set
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, modulus}) ? W'(dbl - {1'b0, modulus}) : dbl[W-1:0];
    sum     = {1'b0, dbl_red} + {1'b0, x_r};
    sum_red = (sum >= {1'b0, modulus}) ? W'(sum - {1'b0, modulus}) : sum[W-1:0];
    acc_nxt = y_r[W-1] ? sum_red : dbl_red;
  end

  // Control: load on go, one multiplier bit per cycle, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        run_r <= 1'b1;
        cnt_r <= mexp_pkg::CNT_W'(W - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulator and multiplier shift register
  always_ff @(posedge clk) begin
    if (req.go) begin
      acc_r <= '0;
      x_r   <= req.x;
      y_r   <= req.y;
    end else if (run_r) begin
      acc_r <= acc_nxt;
      y_r   <= {y_r[W-2:0], 1'b0};
    end
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

// ----- hdl/mexp_chk.sv -----
module mexp_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe
);

  // An accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // A result only shows while an item is in work
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

  // After the result the block is free again
  a_strobe_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy && !out_strobe)
    else $error("block still busy after result");

  // The block only goes idle by delivering a result
  a_free_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(out_strobe))
    else $error("item dropped without result");

endmodule

bind modular_exponentiation_top mexp_chk u_mexp_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int W = mexp_pkg::OPERAND_WIDTH;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_PRIME = W'(64'd4294967291);
  localparam logic [W-1:0] TOP_BIT = W'(64'h80000000);
  localparam int REPORT_LIMIT = 10;
  localparam int RANDOM_ITEMS = 259;

  logic         clk;
  logic         rst_n;
  logic         start;
  logic         busy;
  logic [W-1:0] in_base_value;
  logic [W-1:0] in_exponent_value;
  logic         cfg_we;
  logic [W-1:0] cfg_wdata;
  logic         out_strobe;
  logic [W-1:0] out_power_result;

  // Model copy of the modulus register and the pending powers
  logic [W-1:0] model_modulus;
  logic [W-1:0] expected_powers[$];
  logic [W-1:0] want_power;

  int items_sent;
  int results_seen;
  int mismatches;
  int modulus_settings;

  modular_exponentiation_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_base_value    (in_base_value),
    .in_exponent_value(in_exponent_value),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_power_result (out_power_result)
  );

  // Free-running clock, 2 ns period
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Square-and-multiply over exact double-width products
  function automatic logic [W-1:0] power_mod(input logic [W-1:0] base_in,
                                             input logic [W-1:0] expo_in,
                                             input logic [W-1:0] mod_in);
    logic [2*W-1:0] acc;
    logic [2*W-1:0] base_red;
    logic [2*W-1:0] mod_wide;
    int             bit_idx;
    if (mod_in < W'(2)) begin
      return '0;
    end
    mod_wide = (2*W)'(mod_in);
    base_red = (2*W)'(base_in % mod_in);
    acc      = (2*W)'(1);
    for (bit_idx = W - 1; bit_idx >= 0; bit_idx--) begin
      acc = (acc * acc) % mod_wide;
      if (expo_in[bit_idx]) begin
        acc = (acc * base_red) % mod_wide;
      end
    end
    return acc[W-1:0];
  endfunction

  // Compare each strobed result with the oldest pending power
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      if (expected_powers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("[%0t] unexpected result %0d with nothing pending",
                   $realtime, out_power_result);
        end
      end else begin
        want_power = expected_powers.pop_front();
        if (out_power_result !== want_power) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("[%0t] power_result mismatch: expected %0d, got %0d",
                     $realtime, want_power, out_power_result);
          end
        end
      end
    end
  end

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic [W-1:0] base_v, input logic [W-1:0] expo_v);
    @(posedge clk);
    start             <= 1'b1;
    in_base_value     <= base_v;
    in_exponent_value <= expo_v;
    do begin
      @(posedge clk);
    end while (busy);
    expected_powers.push_back(power_mod(base_v, expo_v, model_modulus));
    items_sent++;
    start <= 1'b0;
  endtask

  // Hold until every pending result has arrived and the block is free
  task automatic wait_idle();
    while (expected_powers.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Write the modulus register while idle
  task automatic write_modulus(input logic [W-1:0] value);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we        <= 1'b0;
    model_modulus  = value;
    modulus_settings++;
    @(posedge clk);
  endtask

  // Reset value of the modulus: zero and unit exponents, reduced bases
  task automatic test_reset_modulus();
    send_item('0, '0);
    send_item('0, W'(5));
    send_item(W'(5), '0);
    send_item(W'(5), W'(1));
    send_item(W'(23), W'(1));
    send_item(W'(46), W'(7));
    send_item(ALL_ONES, ALL_ONES);
    send_item(W'(7), W'(22));
  endtask

  // Moduli of zero and one give zero; two is the smallest real modulus
  task automatic test_degenerate_moduli();
    write_modulus('0);
    send_item(W'(5), W'(3));
    send_item(ALL_ONES, '0);
    write_modulus(W'(1));
    send_item(W'(5), W'(3));
    send_item('0, '0);
    write_modulus(W'(2));
    send_item(W'(3), ALL_ONES);
    send_item(W'(2), '0);
  endtask

  // Full-width moduli: all ones and the largest prime below the top
  task automatic test_wide_modulus();
    write_modulus(ALL_ONES);
    send_item(ALL_ONES - W'(1), W'(2));
    send_item(ALL_ONES, W'(1));
    send_item(W'(32'h12345678), ALL_ONES);
    write_modulus(TOP_PRIME);
    send_item(W'(2), TOP_PRIME - W'(1));
    send_item(ALL_ONES, W'(1));
    send_item(TOP_BIT, TOP_BIT);
  endtask

  // Draw a base, biased toward zero, all ones and multiples of the modulus
  function automatic logic [W-1:0] pick_base();
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return ALL_ONES;
      8:       return W'(model_modulus * $urandom_range(0, 3));
      9:       return W'($urandom_range(0, 31));
      default: return W'($urandom);
    endcase
  endfunction

  // Draw an exponent, biased toward zero, one, all ones and single bits
  function automatic logic [W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      6:       return W'($urandom_range(0, 15));
      7:       return ALL_ONES;
      8:       return W'($urandom_range(0, 1));
      9:       return W'(1) << $urandom_range(0, W - 1);
      default: return W'($urandom);
    endcase
  endfunction

  // Random items in bursts over several modulus settings
  task automatic test_random_phases();
    logic [W-1:0] moduli[7];
    int           per_phase;
    int           sent;
    int           burst;
    int           phase;
    moduli[0] = W'($urandom);
    moduli[1] = W'($urandom_range(2, 255));
    moduli[2] = TOP_PRIME;
    moduli[3] = ALL_ONES;
    moduli[4] = TOP_BIT;
    moduli[5] = W'($urandom_range(2, 65535));
    moduli[6] = W'(3);
    per_phase = RANDOM_ITEMS / 7;
    for (phase = 0; phase < 7; phase++) begin
      write_modulus(moduli[phase]);
      sent = 0;
      while (sent < per_phase) begin
        burst = $urandom_range(1, 8);
        while (burst > 0 && sent < per_phase) begin
          send_item(pick_base(), pick_exponent());
          burst--;
          sent++;
        end
        // Pause: drain everything, wait on the clock, or go straight on
        if ($urandom_range(0, 5) == 0) begin
          wait_idle();
        end else if ($urandom_range(0, 2) != 0) begin
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
    end
  endtask

  // Run all tests in turn
  initial begin
    rst_n             <= 1'b0;
    start             <= 1'b0;
    in_base_value     <= '0;
    in_exponent_value <= '0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    model_modulus      = mexp_pkg::MOD_RESET;
    items_sent         = 0;
    results_seen       = 0;
    mismatches         = 0;
    modulus_settings   = 1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_reset_modulus();
    test_degenerate_moduli();
    test_wide_modulus();
    test_random_phases();

    wait_idle();
    repeat (20) @(posedge clk);
    if (expected_powers.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", expected_powers.size());
    end

    $display("Covered %0d items over %0d modulus settings, moduli 0, 1, 2 and full width.",
             items_sent, modulus_settings);
    $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #10_000_000;
    $display("Timeout with %0d results pending", expected_powers.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
